/* design/dsh_pkg.sv */
// Package for the diamond-square heightmap generator.
// Holds shared constants, types and register indexes; depends on nothing.
`timescale 1ns / 1ps
package dsh_pkg;
  localparam int GRID_LOG2_DEF = 6;
  localparam int CFG_IDX_W = 3;
  localparam int DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_RAND   = 3'd0,
    REG_TIMES_DIV  = 3'd1,
    REG_CORNER_TL  = 3'd2,
    REG_CORNER_FR  = 3'd3,
    REG_CORNER_FC  = 3'd4,
    REG_CORNER_FB  = 3'd5
  } cfg_reg_t;

  // Request to the offset unit and its answer.
  typedef struct packed {
    logic        start;
    logic [30:0] draw;
    logic [9:0]  max_rand;
    logic [15:0] divisor;
  } off_req_t;

  typedef struct packed {
    logic        done;
    logic [41:0] offset;
  } off_rsp_t;
endpackage

/* design/dsh_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps
module dsh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4225,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* design/dsh_offset.sv */
// Iterative offset unit: modulo by the draw range, then rounded division.
// Depends on dsh_pkg.
`timescale 1ns / 1ps
module dsh_offset (
  input  logic              clk,
  input  logic              rst,
  input  dsh_pkg::off_req_t req,
  output dsh_pkg::off_rsp_t rsp
);
  typedef enum logic [2:0] {S_IDLE, S_MUL, S_MOD, S_DIV, S_DONE} st_t;
  st_t st;
  logic [5:0]  cnt;
  logic [30:0] draw;
  logic [25:0] range;
  logic [15:0] td;
  logic [30:0] rem;
  logic [47:0] dividend;
  logic [16:0] drem;
  logic [47:0] quo;
  logic [31:0] rtrial;
  logic [16:0] dtrial;
  logic [26:0] range1;
  logic        done;

  assign range1 = {1'b0, range} + 27'd1;
  assign rtrial = {rem, draw[30]};
  assign dtrial = {drem[15:0], dividend[47]};

  // Restoring modulo over the draw bits, then restoring division by td.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (st)
        S_IDLE: if (req.start) begin
          td <= (req.divisor == 16'd0) ? 16'd1 : req.divisor;
          draw <= req.draw;
          st <= S_MUL;
        end
        S_MUL: begin
          range <= {16'd0, req.max_rand} * {10'd0, td};
          rem <= '0;
          cnt <= 6'd31;
          st <= S_MOD;
        end
        S_MOD: begin
          if ({1'b0, rtrial} >= {6'd0, range1}) rem <= 31'(rtrial - 32'(range1));
          else rem <= rtrial[30:0];
          draw <= {draw[29:0], 1'b0};
          cnt <= cnt - 6'd1;
          if (cnt == 6'd1) st <= S_DIV;
        end
        S_DIV: begin
          if (cnt == 6'd0) begin
            dividend <= {1'b0, rem, 16'd0} + 48'(td[15:1]);
            drem <= '0;
            cnt <= 6'd48;
          end else begin
            if (dtrial >= {1'b0, td}) begin
              drem <= dtrial - {1'b0, td};
              quo <= {quo[46:0], 1'b1};
            end else begin
              drem <= dtrial;
              quo <= {quo[46:0], 1'b0};
            end
            dividend <= {dividend[46:0], 1'b0};
            cnt <= cnt - 6'd1;
            if (cnt == 6'd1) st <= S_DONE;
          end
        end
        S_DONE: begin
          done <= 1'b1;
          st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end
  assign rsp = {done, quo[41:0]};

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    rsp.done |=> !rsp.done) else $error("done held");
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    st == S_MOD |-> td != 16'd0) else $error("zero divisor");
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    st == S_DIV && cnt == 6'd0 |-> {1'b0, rem} < {5'd0, range1})
    else $error("remainder out of range");
endmodule

/* design/diamond_square_heightmap_gen.sv */
// Top level of the diamond-square heightmap generator.
// Depends on dsh_pkg, dsh_ram and dsh_offset.
//
// Channel | Dir | Payload
// s_axis  | in  | tdata: rand_draw[30:0], sign_draw[31]; tuser: restart
// m_axis  | out | tdata: row[6:0], col[13:7], height[45:14]; tlast: last
// cfg     | in  | cfg_index (register number), cfg_data
//
// The block takes a new input only when idle, after the previous item has been
// written and loaded into the output register. The first point of a grid also
// does four corner writes. The offset unit does 31 modulo steps and 48 division
// steps, started on the first of the four grid reads. Reset is synchronous; the
// grid memory is not cleared. A result waiting in the output register does not
// block the input; a second finished result holds the block until the first one
// is taken.
`timescale 1ns / 1ps
module diamond_square_heightmap_gen #(
  parameter int GRID_LOG2 = dsh_pkg::GRID_LOG2_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // rand_draw[30:0], sign_draw[31]
  input  logic        s_axis_tuser,   // restart
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // row[6:0], col[13:7], height[45:14], zero fill
  output logic        m_axis_tlast,   // last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [dsh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int SIDE = (1 << GRID_LOG2) + 1;
  localparam int CELLS = SIDE * SIDE;
  localparam int AW = $clog2(CELLS);
  localparam int CW = GRID_LOG2 + 1;
  localparam int PW = $clog2(2 * GRID_LOG2 + 1);
  localparam logic [CW-1:0] SMAX = CW'(SIDE - 1);
  localparam logic [PW-1:0] PLAST = PW'(2 * GRID_LOG2);

  typedef enum logic [3:0] {
    S_IDLE, S_SETUP, S_CORNER, S_ADDR, S_READ, S_SUM, S_OFF, S_ADD, S_OUT
  } st_t;
  st_t st;

  // Configuration registers.
  logic [9:0]  max_rand;
  logic [15:0] times_div;
  logic signed [31:0] corner [4];

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      max_rand <= 10'd1;
      times_div <= 16'd1000;
      for (int i = 0; i < 4; i++) corner[i] <= 32'sd32768;
    end else if (cfg_valid) begin
      case (dsh_pkg::cfg_reg_t'(cfg_index))
        dsh_pkg::REG_MAX_RAND:  max_rand <= cfg_data[9:0];
        dsh_pkg::REG_TIMES_DIV: times_div <= cfg_data[15:0];
        dsh_pkg::REG_CORNER_TL: corner[0] <= cfg_data;
        dsh_pkg::REG_CORNER_FR: corner[1] <= cfg_data;
        dsh_pkg::REG_CORNER_FC: corner[2] <= cfg_data;
        dsh_pkg::REG_CORNER_FB: corner[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Traversal state.
  logic [PW-1:0] pass_idx;
  logic [CW:0]   outer, inner;
  logic [CW:0]   sq_rows;
  logic [CW-1:0] sq_sp;
  logic [30:0]   draw;
  logic          neg;
  logic [CW-1:0] r, c, h;
  logic [CW:0]   nouter, ninner;
  logic [1:0]    cnt;
  logic signed [33:0] sum;
  logic signed [43:0] val;
  logic          last_pt;
  logic          out_load;

  // Memory port signals.
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;
  logic [31:0]   wdata_sat;

  dsh_ram #(.WIDTH(32), .DEPTH(CELLS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  dsh_pkg::off_req_t oreq;
  dsh_pkg::off_rsp_t orsp;
  dsh_offset u_off (.clk(clk), .rst(rst), .req(oreq), .rsp(orsp));
  assign oreq = {(st == S_SUM) && (cnt == 2'd0), draw, max_rand, times_div};

  function automatic logic [AW-1:0] grid_addr(input logic [CW-1:0] rr,
                                              input logic [CW-1:0] cc);
    grid_addr = AW'(rr * SIDE + cc);
  endfunction

  // Neighbour coordinates for the current point.
  logic [CW-1:0] nr, nc;
  logic [CW:0] rp, cp;
  always_comb begin
    rp = {1'b0, r} + {1'b0, h};
    cp = {1'b0, c} + {1'b0, h};
    nr = r;
    nc = c;
    if (pass_idx[0]) begin
      nr = cnt[0] ? CW'(rp) : r - h;
      nc = cnt[1] ? CW'(cp) : c - h;
    end else begin
      case (cnt)
        2'd0: nc = (c < h) ? SMAX - h : c - h;
        2'd1: nc = (cp > {1'b0, SMAX}) ? h : CW'(cp);
        2'd2: nr = (r < h) ? SMAX - h : r - h;
        default: nr = (rp > {1'b0, SMAX}) ? h : CW'(rp);
      endcase
    end
  end
  assign raddr = grid_addr(nr, nc);

  // Saturate the new height to the signed 32-bit range.
  always_comb begin
    if (val > 44'sd2147483647) wdata_sat = 32'h7FFFFFFF;
    else if (val < -44'sd2147483648) wdata_sat = 32'h80000000;
    else wdata_sat = val[31:0];
  end

  always_comb begin
    we = 1'b0;
    waddr = grid_addr(r, c);
    wdata = wdata_sat;
    if (st == S_CORNER) begin
      we = 1'b1;
      waddr = grid_addr(cnt[0] ? SMAX : '0, cnt[1] ? SMAX : '0);
      wdata = corner[cnt];
    end else if (st == S_ADD) begin
      we = 1'b1;
    end
  end

  assign s_axis_tready = (st == S_IDLE);
  // The output register takes a new result when it is empty or being emptied.
  assign out_load = (st == S_OUT) && (!m_axis_tvalid || m_axis_tready);
  logic [GRID_LOG2-1:0] kk;
  assign kk = GRID_LOG2'((pass_idx - 1) >> 1);

  // Sequencer: setup, optional corner load, four reads, offset, write, output.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      pass_idx <= PW'(1);
      outer <= '0;
      inner <= '0;
      sq_rows <= '0;
      sq_sp <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // The output register empties when the receiver takes the transaction.
      if (m_axis_tready && !out_load) m_axis_tvalid <= 1'b0;
      case (st)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            draw <= s_axis_tdata[30:0];
            neg <= s_axis_tdata[31];
            if (s_axis_tuser) begin
              pass_idx <= PW'(1);
              outer <= '0;
              inner <= '0;
              sq_rows <= '0;
              sq_sp <= '0;
            end
            st <= S_SETUP;
          end
        end
        S_SETUP: begin
          cnt <= 2'd0;
          if (outer == '0 && inner == '0 && !pass_idx[0]) begin
            if (pass_idx == PW'(2)) begin
              sq_rows <= (CW+1)'(3);
              sq_sp <= SMAX;
            end else begin
              sq_rows <= {sq_rows[CW-1:0], 1'b0} - 1'b1;
              sq_sp <= sq_sp >> 1;
            end
          end
          st <= (outer == '0 && inner == '0 && pass_idx == PW'(1)) ? S_CORNER : S_ADDR;
        end
        S_CORNER: begin
          cnt <= cnt + 2'd1;
          if (cnt == 2'd3) st <= S_ADDR;
        end
        S_ADDR: begin
          if (pass_idx[0]) begin
            h <= CW'((1 << GRID_LOG2) >> (kk + 1));
            r <= CW'(((outer << 1) + 1) << (GRID_LOG2 - 1 - kk));
            c <= CW'(((inner << 1) + 1) << (GRID_LOG2 - 1 - kk));
            nouter <= (CW+1)'(1) << kk;
            ninner <= (CW+1)'(1) << kk;
          end else begin
            h <= sq_sp >> 1;
            nouter <= sq_rows;
            r <= CW'(outer * (sq_sp >> 1));
            if (!outer[0]) begin
              ninner <= sq_rows >> 1;
              c <= CW'(inner * sq_sp + (sq_sp >> 1));
            end else begin
              ninner <= sq_rows - (sq_rows >> 1);
              c <= CW'(inner * sq_sp);
            end
          end
          sum <= '0;
          cnt <= 2'd0;
          st <= S_READ;
        end
        S_READ: st <= S_SUM;
        S_SUM: begin
          sum <= sum + 34'(signed'(rdata));
          cnt <= cnt + 2'd1;
          if (cnt == 2'd3) st <= S_OFF;
          else st <= S_READ;
        end
        S_OFF: begin
          if (orsp.done) begin
            val <= neg ? 44'(sum >>> 2) - 44'(orsp.offset)
                       : 44'(sum >>> 2) + 44'(orsp.offset);
            st <= S_ADD;
          end
        end
        S_ADD: begin
          last_pt <= 1'b0;
          if (inner + 1'b1 >= ninner) begin
            inner <= '0;
            if (outer + 1'b1 >= nouter) begin
              outer <= '0;
              if (pass_idx == PLAST) begin
                pass_idx <= PW'(1);
                last_pt <= 1'b1;
              end else pass_idx <= pass_idx + 1'b1;
            end else outer <= outer + 1'b1;
          end else inner <= inner + 1'b1;
          st <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            m_axis_tdata <= {2'b0, wdata_sat, 7'(c), 7'(r)};
            m_axis_tlast <= last_pt;
            m_axis_tvalid <= 1'b1;
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
    && $stable(m_axis_tlast)) else $error("result changed while stalled");
  a_corner_pass: assert property (@(posedge clk) disable iff (rst)
    st == S_CORNER |-> pass_idx == PW'(1)) else $error("corner load outside pass one");
  a_waddr_range: assert property (@(posedge clk) disable iff (rst)
    we |-> waddr < AW'(CELLS)) else $error("grid write out of range");
endmodule
